// ===== design/urbx_pkg.sv =====
// ----------------------------------------------------------------------------
// urbx_pkg
// Shared types and constants for the console UART ring buffer engine.
// ----------------------------------------------------------------------------
package urbx_pkg;

  typedef logic [7:0] byte_t;

  // Item kinds on the input channel.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PUT  = 2'd0;
  localparam kind_t KIND_RECV = 2'd1;
  localparam kind_t KIND_TICK = 2'd2;
  localparam kind_t KIND_READ = 2'd3;

  // Characters with a special meaning.
  localparam byte_t CHAR_LF   = 8'h0A;
  localparam byte_t CHAR_CR   = 8'h0D;
  localparam byte_t CHAR_XOFF = 8'h13;
  localparam byte_t CHAR_XON  = 8'h11;

  // Default ring depths.
  localparam int DEF_TX_DEPTH = 512;
  localparam int DEF_RX_DEPTH = 64;

  // Request from the sequencer to one ring.
  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  // Ring status; empty_next reflects the ring after the current request.
  typedef struct packed {
    logic full;
    logic empty;
    logic empty_next;
  } ring_status_t;

endpackage

// ===== design/uart_ring_buffers_xon_xoff_top.sv =====
// ----------------------------------------------------------------------------
// uart_ring_buffers_xon_xoff_top
// Console UART buffer engine: transmit and receive rings with XON/XOFF.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  input     in_valid / in_ready   kind, data
//  output    out_valid / out_ready dropped, line_valid, line_byte, read_valid,
//                                  read_byte, suspended, tx_empty, input_waiting
//
// An accepted item is registered and then finished; a put of a newline
// makes two ring writes, and a tick or read that hands out a byte first
// waits for a RAM read. A new item is accepted in the cycle the previous
// one finishes. Reset clears the pointers, the hold flag and the handshake
// state; ring contents are not cleared. A stalled result holds the
// item in progress until the result register frees up.
// ----------------------------------------------------------------------------
module uart_ring_buffers_xon_xoff_top
  import urbx_pkg::*;
#(
  parameter int TX_DEPTH = DEF_TX_DEPTH,
  parameter int RX_DEPTH = DEF_RX_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       dropped,
  output logic       line_valid,
  output logic [7:0] line_byte,
  output logic       read_valid,
  output logic [7:0] read_byte,
  output logic       suspended,
  output logic       tx_empty,
  output logic       input_waiting
);

  logic         busy;
  logic         step;
  kind_t        kind_q;
  byte_t        data_q;
  logic         hold;

  logic         out_free;
  logic         act;
  logic         done;
  logic         accept;
  logic         step_next;
  logic         hold_next;

  ring_cmd_t    tx_cmd;
  ring_cmd_t    rx_cmd;
  byte_t        tx_wdata;
  ring_status_t tx_status;
  ring_status_t rx_status;
  byte_t        tx_rdata;
  byte_t        rx_rdata;

  logic         dropped_next;
  logic         line_valid_next;
  byte_t        line_byte_next;
  logic         read_valid_next;
  byte_t        read_byte_next;

  assign out_free = !out_valid || out_ready;
  assign act      = busy && out_free;
  assign in_ready = !busy || done;
  assign accept   = in_valid && in_ready;

  always_comb begin
    tx_cmd          = '0;
    rx_cmd          = '0;
    tx_wdata        = data_q;
    hold_next       = hold;
    done            = 1'b0;
    step_next       = step;
    dropped_next    = 1'b0;
    line_valid_next = 1'b0;
    line_byte_next  = '0;
    read_valid_next = 1'b0;
    read_byte_next  = '0;
    if (act) begin
      unique case (kind_q)
        KIND_PUT: begin
          // A newline goes out as a carriage return followed by the newline.
          if (tx_status.full) begin
            dropped_next = 1'b1;
            done         = 1'b1;
          end else begin
            tx_cmd.push = 1'b1;
            if (step) begin
              tx_wdata = CHAR_LF;
              done     = 1'b1;
            end else if (data_q == CHAR_LF) begin
              tx_wdata  = CHAR_CR;
              step_next = 1'b1;
            end else begin
              done = 1'b1;
            end
          end
        end
        KIND_RECV: begin
          done = 1'b1;
          if (data_q == CHAR_XOFF) begin
            hold_next = 1'b1;
          end else if (data_q == CHAR_XON) begin
            hold_next = 1'b0;
          end else if (!rx_status.full) begin
            rx_cmd.push = 1'b1;
          end
        end
        KIND_TICK: begin
          if (step) begin
            done            = 1'b1;
            line_valid_next = 1'b1;
            line_byte_next  = tx_rdata;
          end else if (!hold && !tx_status.empty) begin
            tx_cmd.pop = 1'b1;
            step_next  = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        KIND_READ: begin
          if (step) begin
            done            = 1'b1;
            read_valid_next = 1'b1;
            read_byte_next  = rx_rdata;
          end else if (!rx_status.empty) begin
            rx_cmd.pop = 1'b1;
            step_next  = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 1'b0;
      hold <= 1'b0;
    end else begin
      hold <= hold_next;
      if (accept) begin
        busy <= 1'b1;
        step <= 1'b0;
      end else if (done) begin
        busy <= 1'b0;
        step <= 1'b0;
      end else begin
        step <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind;
      data_q <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      dropped       <= dropped_next;
      line_valid    <= line_valid_next;
      line_byte     <= line_byte_next;
      read_valid    <= read_valid_next;
      read_byte     <= read_byte_next;
      suspended     <= hold_next;
      tx_empty      <= tx_status.empty_next;
      input_waiting <= !rx_status.empty_next;
    end
  end

  urbx_ring #(
    .DEPTH (TX_DEPTH)
  ) u_tx_ring (
    .clk    (clk),
    .rst    (rst),
    .cmd    (tx_cmd),
    .wdata  (tx_wdata),
    .status (tx_status),
    .rdata  (tx_rdata)
  );

  urbx_ring #(
    .DEPTH (RX_DEPTH)
  ) u_rx_ring (
    .clk    (clk),
    .rst    (rst),
    .cmd    (rx_cmd),
    .wdata  (data_q),
    .status (rx_status),
    .rdata  (rx_rdata)
  );

endmodule

// ===== design/urbx_ram.sv =====
// ----------------------------------------------------------------------------
// urbx_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module urbx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/urbx_ring.sv =====
// ----------------------------------------------------------------------------
// urbx_ring
// Ring buffer holding DEPTH-1 bytes. A pop reads the oldest entry; its data
// appears on rdata in the following cycle.
// ----------------------------------------------------------------------------
module urbx_ring
  import urbx_pkg::*;
#(
  parameter int DEPTH = DEF_RX_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  ring_cmd_t    cmd,
  input  byte_t        wdata,
  output ring_status_t status,
  output byte_t        rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_inc;
  logic [AW-1:0] rd_inc;
  logic [AW-1:0] wr_ptr_next;
  logic [AW-1:0] rd_ptr_next;

  assign wr_inc = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
  assign rd_inc = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);

  assign wr_ptr_next = cmd.push ? wr_inc : wr_ptr;
  assign rd_ptr_next = cmd.pop  ? rd_inc : rd_ptr;

  assign status.full       = (wr_inc == rd_ptr);
  assign status.empty      = (wr_ptr == rd_ptr);
  assign status.empty_next = (wr_ptr_next == rd_ptr_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
    end
  end

  // The read address is the read pointer, so the entry being popped is
  // captured at the edge that advances the pointer.
  urbx_ram #(
    .WIDTH ($bits(byte_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_ptr),
    .wdata (wdata),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

endmodule

// ===== tb/uart_ring_buffers_xon_xoff_top_test.sv =====
// ----------------------------------------------------------------------------
// uart_ring_buffers_xon_xoff_top_test
// Self-checking bench for the console UART ring buffer engine. A behavioral
// model of both rings and the XON/XOFF hold flag predicts one result per
// accepted transaction. Directed items cover the corner cases, then random
// traffic, ring overflow runs and a long output stall exercise the block.
// ----------------------------------------------------------------------------
module uart_ring_buffers_xon_xoff_top_test;
  import urbx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TX_DEPTH    = DEF_TX_DEPTH;
  localparam int RX_DEPTH    = DEF_RX_DEPTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic  dropped;
    logic  line_valid;
    byte_t line_byte;
    logic  read_valid;
    byte_t read_byte;
    logic  suspended;
    logic  tx_empty;
    logic  input_waiting;
  } console_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = KIND_PUT;
  logic [7:0] data = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       dropped;
  logic       line_valid;
  logic [7:0] line_byte;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       suspended;
  logic       tx_empty;
  logic       input_waiting;

  // Console state as the predictor sees it.
  byte_t tx_ring_mem [TX_DEPTH];
  byte_t rx_ring_mem [RX_DEPTH];
  int    tx_wr_ptr = 0;
  int    tx_rd_ptr = 0;
  int    rx_wr_ptr = 0;
  int    rx_rd_ptr = 0;
  logic  tx_held   = 1'b0;

  console_result_t pending_results[$];
  int mismatches  = 0;
  int cycle_count = 0;

  // Sender burst shaping and receiver stall shaping.
  int max_gap    = 6;
  int burst_left = 4;
  int stall_pct  = 0;
  int hold_request = 0;
  int hold_served  = 0;
  int hold_left    = 0;
  int run_left     = 0;
  logic run_level  = 1'b1;

  uart_ring_buffers_xon_xoff_top #(
    .TX_DEPTH(TX_DEPTH),
    .RX_DEPTH(RX_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .data         (data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dropped      (dropped),
    .line_valid   (line_valid),
    .line_byte    (line_byte),
    .read_valid   (read_valid),
    .read_byte    (read_byte),
    .suspended    (suspended),
    .tx_empty     (tx_empty),
    .input_waiting(input_waiting)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int ring_next(int ptr, int depth);
    return (ptr + 1 >= depth) ? 0 : ptr + 1;
  endfunction

  function automatic int tx_fill();
    return (tx_wr_ptr + TX_DEPTH - tx_rd_ptr) % TX_DEPTH;
  endfunction

  function automatic bit tx_enqueue(byte_t b);
    if (ring_next(tx_wr_ptr, TX_DEPTH) == tx_rd_ptr) return 1'b0;
    tx_ring_mem[tx_wr_ptr] = b;
    tx_wr_ptr = ring_next(tx_wr_ptr, TX_DEPTH);
    return 1'b1;
  endfunction

  function automatic console_result_t console_step(kind_t k, byte_t d);
    console_result_t r;
    r = '0;
    case (k)
      KIND_PUT: begin
        // A newline goes out as CR then LF; a partial queue still flags the drop.
        if (d == CHAR_LF) begin
          if (!tx_enqueue(CHAR_CR)) r.dropped = 1'b1;
          else if (!tx_enqueue(CHAR_LF)) r.dropped = 1'b1;
        end else if (!tx_enqueue(d)) begin
          r.dropped = 1'b1;
        end
      end
      KIND_RECV: begin
        if (d == CHAR_XOFF) begin
          tx_held = 1'b1;
        end else if (d == CHAR_XON) begin
          tx_held = 1'b0;
        end else if (ring_next(rx_wr_ptr, RX_DEPTH) != rx_rd_ptr) begin
          rx_ring_mem[rx_wr_ptr] = d;
          rx_wr_ptr = ring_next(rx_wr_ptr, RX_DEPTH);
        end
      end
      KIND_TICK: begin
        if (!tx_held && tx_rd_ptr != tx_wr_ptr) begin
          r.line_valid = 1'b1;
          r.line_byte  = tx_ring_mem[tx_rd_ptr];
          tx_rd_ptr = ring_next(tx_rd_ptr, TX_DEPTH);
        end
      end
      default: begin
        if (rx_rd_ptr != rx_wr_ptr) begin
          r.read_valid = 1'b1;
          r.read_byte  = rx_ring_mem[rx_rd_ptr];
          rx_rd_ptr = ring_next(rx_rd_ptr, RX_DEPTH);
        end
      end
    endcase
    r.suspended     = tx_held;
    r.tx_empty      = (tx_rd_ptr == tx_wr_ptr);
    r.input_waiting = (rx_rd_ptr != rx_wr_ptr);
    return r;
  endfunction

  // ------------------------------------------------------------------ driving

  task automatic send_item(kind_t k, byte_t d);
    kind     <= k;
    data     <= d;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(console_step(k, d));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && max_gap > 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(max_gap, 1)) @(posedge clk);
      burst_left = $urandom_range(16, 1);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic byte_t pick_byte(int special_pct);
    if ($urandom_range(99) < special_pct) begin
      case ($urandom_range(3))
        0:       return CHAR_LF;
        1:       return CHAR_CR;
        2:       return CHAR_XON;
        default: return CHAR_XOFF;
      endcase
    end
    return byte_t'($urandom_range(255));
  endfunction

  function automatic kind_t pick_kind();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return KIND_PUT;
    if (roll < 55) return KIND_RECV;
    if (roll < 80) return KIND_TICK;
    return KIND_READ;
  endfunction

  // -------------------------------------------------------------------- tests

  task automatic test_directed();
    send_item(KIND_PUT, 8'h00);
    send_item(KIND_PUT, 8'hFF);
    send_item(KIND_PUT, CHAR_LF);
    send_item(KIND_PUT, CHAR_CR);
    send_item(KIND_RECV, CHAR_XOFF);
    send_item(KIND_TICK, 8'h00);      // held, nothing goes out
    send_item(KIND_RECV, CHAR_XON);
    repeat (5) send_item(KIND_TICK, 8'h00);
    send_item(KIND_TICK, 8'hFF);      // ring now empty
    send_item(KIND_READ, 8'h00);      // nothing received yet
    send_item(KIND_RECV, 8'h00);
    send_item(KIND_RECV, 8'hFF);
    send_item(KIND_RECV, CHAR_XON);   // flow control is never queued
    send_item(KIND_READ, 8'hFF);
    send_item(KIND_READ, 8'h00);
    send_item(KIND_READ, 8'h5A);
    send_item(KIND_PUT, 8'hA5);
    send_item(KIND_TICK, 8'hFF);
    drain_results();
  endtask

  task automatic test_random_mix(int count, int special_pct);
    kind_t k;
    repeat (count) begin
      k = pick_kind();
      send_item(k, pick_byte(special_pct));
    end
    drain_results();
  endtask

  task automatic test_tx_overflow();
    byte_t b;
    int    n;
    send_item(KIND_RECV, CHAR_XON);
    // Fill to one entry short of capacity, so a newline only gets its CR in.
    while (tx_fill() < TX_DEPTH - 2) begin
      b = pick_byte(5);
      if (b == CHAR_LF && tx_fill() > TX_DEPTH - 4) b = 8'h7E;
      send_item(KIND_PUT, b);
    end
    send_item(KIND_PUT, CHAR_LF);
    send_item(KIND_PUT, CHAR_LF);
    send_item(KIND_PUT, byte_t'($urandom_range(255)));
    n = 0;
    while (tx_fill() > 0) begin
      n++;
      if (n == 100) send_item(KIND_RECV, CHAR_XOFF);
      if (n == 104) send_item(KIND_RECV, CHAR_XON);
      send_item(KIND_TICK, byte_t'($urandom_range(255)));
    end
    send_item(KIND_TICK, byte_t'($urandom_range(255)));
    drain_results();
  endtask

  task automatic test_rx_overflow();
    repeat (RX_DEPTH + 6) send_item(KIND_RECV, byte_t'($urandom_range(255)));
    repeat (RX_DEPTH + 6) send_item(KIND_READ, byte_t'($urandom_range(255)));
    drain_results();
  endtask

  task automatic test_output_backpressure();
    int saved_gap;
    saved_gap = max_gap;
    max_gap   = 0;
    hold_request++;
    repeat (40) send_item(pick_kind(), pick_byte(20));
    max_gap = saved_gap;
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    stall_pct = 0;
    max_gap   = 0;
    test_directed();

    stall_pct = 30;
    max_gap   = 6;
    test_random_mix(350, 25);

    stall_pct = 20;
    test_tx_overflow();

    stall_pct = 50;
    test_rx_overflow();

    test_output_backpressure();

    // A stretch with no idling on either side.
    stall_pct = 0;
    max_gap   = 0;
    test_random_mix(350, 40);

    if (mismatches == 0) begin
      $display("uart_ring_buffers_xon_xoff_top_test: PASS");
    end else begin
      $display("uart_ring_buffers_xon_xoff_top_test: FAIL");
    end
    $finish;
  end

  // ----------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (hold_request != hold_served) begin
      hold_served = hold_request;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_level = ($urandom_range(99) >= stall_pct);
        run_left  = $urandom_range(8, 1);
      end
      run_left--;
      out_ready <= run_level;
    end
  end

  // ------------------------------------------------------------------ checker

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    console_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transaction with nothing expected", $realtime);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("dropped", want.dropped, dropped);
        compare_field("line_valid", want.line_valid, line_valid);
        compare_field("line_byte", want.line_byte, line_byte);
        compare_field("read_valid", want.read_valid, read_valid);
        compare_field("read_byte", want.read_byte, read_byte);
        compare_field("suspended", want.suspended, suspended);
        compare_field("tx_empty", want.tx_empty, tx_empty);
        compare_field("input_waiting", want.input_waiting, input_waiting);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime,
               pending_results.size());
      $display("uart_ring_buffers_xon_xoff_top_test: FAIL");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
design/urbx_pkg.sv
design/urbx_ram.sv
design/urbx_ring.sv
design/uart_ring_buffers_xon_xoff_top.sv
tb/uart_ring_buffers_xon_xoff_top_test.sv
